FILE: sv/rycc_pkg.sv
// Package for the RGB to YCbCr converter with chroma pairing and rebuild.
// Fixed-point widths, Q-format coefficients, MAC control type and rounding helpers.
// No dependencies.
`default_nettype none

package rycc_pkg;

    localparam int FRAC_BITS = 16;

    // Coefficient: signed, magnitude below 2.0 in Q(FRAC_BITS)
    localparam int COEF_W = FRAC_BITS + 2;
    // Level-shifted difference in Q(FRAC_BITS): |X' - Y| < 256
    localparam int DIFF_W = FRAC_BITS + 10;
    // MAC accumulator: one difference times one coefficient
    localparam int ACC_W  = DIFF_W + COEF_W;

    localparam int PIX_W  = 8;
    localparam int CHR_W  = 9;

    // round(c * 2^FRAC_BITS), c in thousandths, ties up
    localparam logic signed [COEF_W-1:0] C_Y_R =
        COEF_W'(((64'd299 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic signed [COEF_W-1:0] C_Y_G =
        COEF_W'(((64'd587 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic signed [COEF_W-1:0] C_Y_B =
        COEF_W'(((64'd114 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic signed [COEF_W-1:0] C_CB =
        COEF_W'(((64'd565 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic signed [COEF_W-1:0] C_CR =
        COEF_W'(((64'd713 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic signed [COEF_W-1:0] C_R_CR =
        COEF_W'(((64'd1403 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic signed [COEF_W-1:0] C_B_CB =
        COEF_W'(((64'd1770 << FRAC_BITS) + 64'd500) / 64'd1000);
    // green terms are subtracted: stored negated
    localparam logic signed [COEF_W-1:0] C_G_CB_NEG =
        COEF_W'(64'd0 - ((64'd344 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic signed [COEF_W-1:0] C_G_CR_NEG =
        COEF_W'(64'd0 - ((64'd714 << FRAC_BITS) + 64'd500) / 64'd1000);

    localparam logic signed [ACC_W-1:0] HALF_Q   = ACC_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] ONE_Q    = ACC_W'(64'd1 << FRAC_BITS);
    localparam logic signed [ACC_W-1:0] OFFSET_Q = ACC_W'(64'd128 << FRAC_BITS);
    localparam logic signed [ACC_W-1:0] MAX_Q    = ACC_W'(64'd255 << FRAC_BITS);

    typedef struct packed {
        logic en;          // load the accumulator this cycle
        logic accumulate;  // add to the accumulator instead of the base
    } mac_ctrl_t;

    // v / 2^FRAC_BITS, to nearest, ties toward +inf
    function automatic logic signed [ACC_W-1:0] round_frac(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        begin
            t = v + HALF_Q;
            return t >>> FRAC_BITS;
        end
    endfunction

    // v / 2^(FRAC_BITS+1), to nearest, ties toward +inf (pair average)
    function automatic logic signed [ACC_W-1:0] round_pair(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        begin
            t = v + ONE_Q;
            return t >>> (FRAC_BITS + 1);
        end
    endfunction

    // clamp to 0..255 in Q(FRAC_BITS), then round to an integer
    function automatic logic [PIX_W-1:0] rebuild_pix(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        begin
            t = v + HALF_Q;
            if (v < 0)
            begin
                return '0;
            end
            if (v > MAX_Q)
            begin
                return {PIX_W{1'b1}};
            end
            t = t >>> FRAC_BITS;
            return t[PIX_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/rycc_mac.sv
// Shared multiply-accumulate unit of the converter.
// Depends on rycc_pkg (widths, mac_ctrl_t).
`default_nettype none

module rycc_mac
    import rycc_pkg::*;
(
    input  wire logic                      clk,
    input  wire mac_ctrl_t                 ctrl,
    input  wire logic signed [ACC_W-1:0]   base,
    input  wire logic signed [DIFF_W-1:0]  op_a,
    input  wire logic signed [COEF_W-1:0]  op_b,
    output      logic signed [ACC_W-1:0]   acc
);

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] prod;
    logic signed [ACC_W-1:0] addend;

    always_comb
    begin
        prod   = op_a * op_b;
        addend = ctrl.accumulate ? acc_reg : base;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            acc_reg <= addend + prod;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

FILE: sv/rgb_ycbcr_chroma_pair_roundtrip.sv
// Top level: RGB pixel to level-shifted YCbCr with optional chroma pairing and RGB rebuild.
// Sequence: a pixel beat runs Y0..Y2, CB, CR and SPLIT, then RED, BLUE, GRN0, GRN1 and PUT
// before result_valid rises; in pair mode the second pixel's SPLIT sends the held pixel out first,
// then RED..PUT run again for its own result. One multiplier does every product, so a new pixel
// is taken only back in IDLE, after its Y/Cb/Cr steps and every result it emits; output stall holds it longer.
// Reset: async active low; clears mode, pair phase, pending flag, sequencer and result valid.
`default_nettype none

module rgb_ycbcr_chroma_pair_roundtrip
    import rycc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // configuration: chroma_mode
    input  wire logic                     cfg_we,
    input  wire logic                     cfg_wdata,
    // pixel channel
    input  wire logic                     pixel_valid,
    output      logic                     pixel_stall,
    input  wire logic [PIX_W-1:0]         red,
    input  wire logic [PIX_W-1:0]         green,
    input  wire logic [PIX_W-1:0]         blue,
    // result channel
    output      logic                     result_valid,
    input  wire logic                     result_stall,
    output      logic signed [PIX_W-1:0]  luma,
    output      logic signed [CHR_W-1:0]  chroma_blue,
    output      logic signed [CHR_W-1:0]  chroma_red,
    output      logic [PIX_W-1:0]         red_rebuilt,
    output      logic [PIX_W-1:0]         green_rebuilt,
    output      logic [PIX_W-1:0]         blue_rebuilt,
    output      logic                     last
);

    // Sequencer. Y0..Y2 accumulate luma, CB/CR form the unrounded chroma,
    // SPLIT decides hold / emit, RED..GRN1 rebuild one pixel, PUT hands it off.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_Y0    = 4'd1;
    localparam logic [3:0] ST_Y1    = 4'd2;
    localparam logic [3:0] ST_Y2    = 4'd3;
    localparam logic [3:0] ST_CB    = 4'd4;
    localparam logic [3:0] ST_CR    = 4'd5;
    localparam logic [3:0] ST_SPLIT = 4'd6;
    localparam logic [3:0] ST_RED   = 4'd7;
    localparam logic [3:0] ST_BLUE  = 4'd8;
    localparam logic [3:0] ST_GRN0  = 4'd9;
    localparam logic [3:0] ST_GRN1  = 4'd10;
    localparam logic [3:0] ST_PUT   = 4'd11;

    // control state
    logic [3:0] state_reg, state_next;
    logic       mode_reg, mode_next;          // chroma_mode
    logic       phase_reg, phase_next;        // 1: first pixel of a pair is held
    logic       pend_reg, pend_next;          // second pixel of a pair still to emit
    logic       out_valid_reg, out_valid_next;

    // payload
    logic signed [CHR_W-1:0]  r_reg, g_reg, b_reg;   // level-shifted input
    logic signed [DIFF_W-1:0] yq_reg;                // unrounded Y
    logic signed [DIFF_W-1:0] cbq_reg;               // unrounded Cb, Q(FRAC_BITS)
    logic signed [PIX_W-1:0]  held_y_reg;
    logic signed [DIFF_W-1:0] held_cb_reg, held_cr_reg;
    logic signed [PIX_W-1:0]  pend_y_reg;
    logic signed [PIX_W-1:0]  emit_y_reg;
    logic signed [CHR_W-1:0]  emit_cb_reg, emit_cr_reg;
    logic                     emit_last_reg;
    logic [PIX_W-1:0]         red_res_reg, blue_res_reg;

    logic signed [PIX_W-1:0]  luma_reg;
    logic signed [CHR_W-1:0]  cb_out_reg, cr_out_reg;
    logic [PIX_W-1:0]         r_out_reg, g_out_reg, b_out_reg;
    logic                     last_reg;

    // MAC hookup
    mac_ctrl_t                mac_ctrl;
    logic signed [ACC_W-1:0]  mac_base;
    logic signed [DIFF_W-1:0] mac_a;
    logic signed [COEF_W-1:0] mac_b;
    logic signed [ACC_W-1:0]  acc;

    // rounding taps
    logic signed [ACC_W-1:0]  acc_round;
    logic signed [DIFF_W-1:0] crq;
    logic signed [ACC_W-1:0]  y_round, cb_full, cr_full, cb_pair, cr_pair;
    logic signed [ACC_W-1:0]  rebuild_base;
    logic                     pixel_take;
    logic                     slot_free;

    rycc_mac u_mac (
        .clk   (clk),
        .ctrl  (mac_ctrl),
        .base  (mac_base),
        .op_a  (mac_a),
        .op_b  (mac_b),
        .acc   (acc)
    );

    assign pixel_stall = (state_reg != ST_IDLE);
    assign pixel_take  = pixel_valid && !pixel_stall;
    assign slot_free   = !out_valid_reg || !result_stall;

    always_comb
    begin
        acc_round    = round_frac(acc);
        crq          = acc_round[DIFF_W-1:0];
        y_round      = round_frac(ACC_W'(yq_reg));
        cb_full      = round_frac(ACC_W'(cbq_reg));
        cr_full      = round_frac(ACC_W'(crq));
        cb_pair      = round_pair(ACC_W'(held_cb_reg) + ACC_W'(cbq_reg));
        cr_pair      = round_pair(ACC_W'(held_cr_reg) + ACC_W'(crq));
        rebuild_base = (ACC_W'(emit_y_reg) <<< FRAC_BITS) + OFFSET_Q;
    end

    // next state and MAC operand selection
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        phase_next     = phase_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && result_stall;
        mac_ctrl       = '0;
        mac_base       = '0;
        mac_a          = '0;
        mac_b          = '0;

        // mode write drops any half-built pair
        if (cfg_we)
        begin
            mode_next  = cfg_wdata;
            phase_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (pixel_valid)
                begin
                    state_next = ST_Y0;
                end
            end
            ST_Y0:
            begin
                mac_ctrl.en = 1'b1;
                mac_a       = DIFF_W'(r_reg);
                mac_b       = C_Y_R;
                state_next  = ST_Y1;
            end
            ST_Y1:
            begin
                mac_ctrl    = '{en: 1'b1, accumulate: 1'b1};
                mac_a       = DIFF_W'(g_reg);
                mac_b       = C_Y_G;
                state_next  = ST_Y2;
            end
            ST_Y2:
            begin
                mac_ctrl    = '{en: 1'b1, accumulate: 1'b1};
                mac_a       = DIFF_W'(b_reg);
                mac_b       = C_Y_B;
                state_next  = ST_CB;
            end
            ST_CB:
            begin
                // acc holds Y here
                mac_ctrl.en = 1'b1;
                mac_a       = (DIFF_W'(b_reg) <<< FRAC_BITS) - acc[DIFF_W-1:0];
                mac_b       = C_CB;
                state_next  = ST_CR;
            end
            ST_CR:
            begin
                mac_ctrl.en = 1'b1;
                mac_a       = (DIFF_W'(r_reg) <<< FRAC_BITS) - yq_reg;
                mac_b       = C_CR;
                state_next  = ST_SPLIT;
            end
            ST_SPLIT:
            begin
                if (!mode_reg)
                begin
                    pend_next  = 1'b0;
                    state_next = ST_RED;
                end
                else if (!phase_reg)
                begin
                    phase_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    phase_next = 1'b0;
                    pend_next  = 1'b1;
                    state_next = ST_RED;
                end
            end
            ST_RED:
            begin
                mac_ctrl.en = 1'b1;
                mac_base    = rebuild_base;
                mac_a       = DIFF_W'(emit_cr_reg);
                mac_b       = C_R_CR;
                state_next  = ST_BLUE;
            end
            ST_BLUE:
            begin
                mac_ctrl.en = 1'b1;
                mac_base    = rebuild_base;
                mac_a       = DIFF_W'(emit_cb_reg);
                mac_b       = C_B_CB;
                state_next  = ST_GRN0;
            end
            ST_GRN0:
            begin
                mac_ctrl.en = 1'b1;
                mac_base    = rebuild_base;
                mac_a       = DIFF_W'(emit_cb_reg);
                mac_b       = C_G_CB_NEG;
                state_next  = ST_GRN1;
            end
            ST_GRN1:
            begin
                mac_ctrl    = '{en: 1'b1, accumulate: 1'b1};
                mac_a       = DIFF_W'(emit_cr_reg);
                mac_b       = C_G_CR_NEG;
                state_next  = ST_PUT;
            end
            ST_PUT:
            begin
                // wait for the output register; an older stalled beat holds the sequencer here
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (pend_reg)
                    begin
                        pend_next  = 1'b0;
                        state_next = ST_RED;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= 1'b0;
            phase_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            phase_reg     <= phase_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (pixel_take)
        begin
            r_reg <= $signed({1'b0, red})   - 9'sd128;
            g_reg <= $signed({1'b0, green}) - 9'sd128;
            b_reg <= $signed({1'b0, blue})  - 9'sd128;
        end
        if (state_reg == ST_CB)
        begin
            yq_reg <= acc[DIFF_W-1:0];
        end
        if (state_reg == ST_CR)
        begin
            cbq_reg <= acc_round[DIFF_W-1:0];
        end
        if (state_reg == ST_SPLIT)
        begin
            if (!mode_reg)
            begin
                emit_y_reg    <= y_round[PIX_W-1:0];
                emit_cb_reg   <= cb_full[CHR_W-1:0];
                emit_cr_reg   <= cr_full[CHR_W-1:0];
                emit_last_reg <= 1'b1;
            end
            else if (!phase_reg)
            begin
                held_y_reg  <= y_round[PIX_W-1:0];
                held_cb_reg <= cbq_reg;
                held_cr_reg <= crq;
            end
            else
            begin
                // held pixel goes out first, shared chroma for both
                emit_y_reg    <= held_y_reg;
                emit_cb_reg   <= cb_pair[CHR_W-1:0];
                emit_cr_reg   <= cr_pair[CHR_W-1:0];
                emit_last_reg <= 1'b0;
                pend_y_reg    <= y_round[PIX_W-1:0];
            end
        end
        if (state_reg == ST_BLUE)
        begin
            red_res_reg <= rebuild_pix(acc);
        end
        if (state_reg == ST_GRN0)
        begin
            blue_res_reg <= rebuild_pix(acc);
        end
        if ((state_reg == ST_PUT) && slot_free)
        begin
            luma_reg   <= emit_y_reg;
            cb_out_reg <= emit_cb_reg;
            cr_out_reg <= emit_cr_reg;
            r_out_reg  <= red_res_reg;
            g_out_reg  <= rebuild_pix(acc);
            b_out_reg  <= blue_res_reg;
            last_reg   <= emit_last_reg;
            if (pend_reg)
            begin
                emit_y_reg    <= pend_y_reg;
                emit_last_reg <= 1'b1;
            end
        end
    end

    assign result_valid  = out_valid_reg;
    assign luma          = luma_reg;
    assign chroma_blue   = cb_out_reg;
    assign chroma_red    = cr_out_reg;
    assign red_rebuilt   = r_out_reg;
    assign green_rebuilt = g_out_reg;
    assign blue_rebuilt  = b_out_reg;
    assign last          = last_reg;

    // a new result beat only comes out of the hand-off state
    a_valid_from_put: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_PUT))
        else $error("result beat raised outside hand-off");

    // a pixel is held only in pair mode
    a_phase_needs_mode: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> mode_reg)
        else $error("pair phase set in full chroma mode");

    // while the second pixel is pending, the pixel in flight is not the last
    a_pend_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && (state_reg != ST_SPLIT)) |-> !emit_last_reg)
        else $error("first of pair marked last");

    // full chroma mode always rebuilds right after the split
    a_full_mode_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SPLIT && !mode_reg) |=> (state_reg == ST_RED))
        else $error("full chroma pixel not emitted");

endmodule

`default_nettype wire

FILE: test/tb_rgb_ycbcr_chroma_pair_roundtrip.sv
// Testbench for rgb_ycbcr_chroma_pair_roundtrip: directed pixel table, then random pixel
// phases in both chroma modes, every result beat checked against a hand-written result or an in-bench predictor.
// Depends on rycc_pkg (widths, FRAC_BITS) and the converter RTL only.

module tb_rgb_ycbcr_chroma_pair_roundtrip
    import rycc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Idle time after the last expected beat before a mode write or the end.
    // Covers a first-of-pair pixel still in flight, with margin.
    localparam int SETTLE_CYCLES = 48;
    // Receiver hold-off long enough to back up the block onto its pixel input
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AT_PIXEL = 320;
    // Pixel / beat counts between which neither side idles
    localparam int QUIET_FROM    = 500;
    localparam int QUIET_TO      = 700;
    localparam int NUM_PHASES    = 8;
    localparam longint RUN_LIMIT_NS = 3_000_000;

    // Q(FRAC_BITS) coefficients, rounded from thousandths with ties up
    localparam longint ONE_FX  = longint'(1) << FRAC_BITS;
    localparam longint HALF_FX = longint'(1) << (FRAC_BITS - 1);
    localparam longint K_Y_R   = ((longint'(299) << FRAC_BITS) + 500) / 1000;
    localparam longint K_Y_G   = ((longint'(587) << FRAC_BITS) + 500) / 1000;
    localparam longint K_Y_B   = ((longint'(114) << FRAC_BITS) + 500) / 1000;
    localparam longint K_CB    = ((longint'(565) << FRAC_BITS) + 500) / 1000;
    localparam longint K_CR    = ((longint'(713) << FRAC_BITS) + 500) / 1000;
    localparam longint K_R_CR  = ((longint'(1403) << FRAC_BITS) + 500) / 1000;
    localparam longint K_G_CB  = ((longint'(344) << FRAC_BITS) + 500) / 1000;
    localparam longint K_G_CR  = ((longint'(714) << FRAC_BITS) + 500) / 1000;
    localparam longint K_B_CB  = ((longint'(1770) << FRAC_BITS) + 500) / 1000;

    localparam logic MODE_FULL = 1'b0;   // chroma per pixel
    localparam logic MODE_PAIR = 1'b1;   // chroma averaged over a pixel pair

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_pixel_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] luma;
        logic signed [CHR_W-1:0] chroma_blue;
        logic signed [CHR_W-1:0] chroma_red;
        logic [PIX_W-1:0]        red_rebuilt;
        logic [PIX_W-1:0]        green_rebuilt;
        logic [PIX_W-1:0]        blue_rebuilt;
        logic                    last;
    } ycc_beat_t;

    typedef enum logic { ROW_PIXEL, ROW_MODE } row_kind_t;

    typedef struct {
        row_kind_t  kind;
        rgb_pixel_t pix;
        logic       mode;
        bit         typed;   // want holds a hand-written result
        ycc_beat_t  want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    logic pixel_valid = 1'b0;
    logic pixel_stall;
    logic [PIX_W-1:0] red = '0;
    logic [PIX_W-1:0] green = '0;
    logic [PIX_W-1:0] blue = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic signed [PIX_W-1:0] luma;
    logic signed [CHR_W-1:0] chroma_blue;
    logic signed [CHR_W-1:0] chroma_red;
    logic [PIX_W-1:0] red_rebuilt;
    logic [PIX_W-1:0] green_rebuilt;
    logic [PIX_W-1:0] blue_rebuilt;
    logic last;

    // Beats still owed by the block, oldest first
    ycc_beat_t pending_ycc[$];
    int errors = 0;
    int pixels_accepted = 0;
    int beats_checked = 0;
    bit hold_armed = 1'b0;
    bit hold_done = 1'b0;

    // Predictor copy of the block's mode and pairing state
    logic   ycc_mode = MODE_FULL;
    logic   pair_half = 1'b0;
    longint held_y = 0;
    longint held_cb_fx = 0;
    longint held_cr_fx = 0;

    rgb_ycbcr_chroma_pair_roundtrip uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .pixel_valid   (pixel_valid),
        .pixel_stall   (pixel_stall),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .luma          (luma),
        .chroma_blue   (chroma_blue),
        .chroma_red    (chroma_red),
        .red_rebuilt   (red_rebuilt),
        .green_rebuilt (green_rebuilt),
        .blue_rebuilt  (blue_rebuilt),
        .last          (last)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // v / 2^s to nearest, ties toward +inf; >>> on longint floors
    function automatic longint round_fx(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // clamp a Q(FRAC_BITS) level to 0..255, then round to an integer
    function automatic logic [PIX_W-1:0] clamp_pixel(input longint acc);
        longint t;
        t = acc;
        if (t < 0)
            t = 0;
        if (t > 255 * ONE_FX)
            t = 255 * ONE_FX;
        t = (t + HALF_FX) >>> FRAC_BITS;
        return t[PIX_W-1:0];
    endfunction

    function automatic ycc_beat_t rebuild_beat(input longint y, input longint cb,
                                               input longint cr, input logic fin);
        ycc_beat_t o;
        longint base;
        base = (y + 128) * ONE_FX;
        o.luma          = y[PIX_W-1:0];
        o.chroma_blue   = cb[CHR_W-1:0];
        o.chroma_red    = cr[CHR_W-1:0];
        o.red_rebuilt   = clamp_pixel(base + K_R_CR * cr);
        o.green_rebuilt = clamp_pixel(base - K_G_CB * cb - K_G_CR * cr);
        o.blue_rebuilt  = clamp_pixel(base + K_B_CB * cb);
        o.last          = fin;
        return o;
    endfunction

    // Convert one accepted pixel and queue the beats it causes
    task automatic predict_pixel(input rgb_pixel_t p);
        longint r_s, g_s, b_s, y_fx, cb_fx, cr_fx, y, cb, cr;
        r_s = longint'(p.red) - 128;
        g_s = longint'(p.green) - 128;
        b_s = longint'(p.blue) - 128;
        y_fx  = K_Y_R * r_s + K_Y_G * g_s + K_Y_B * b_s;
        cb_fx = round_fx(K_CB * (b_s * ONE_FX - y_fx), FRAC_BITS);
        cr_fx = round_fx(K_CR * (r_s * ONE_FX - y_fx), FRAC_BITS);
        y     = round_fx(y_fx, FRAC_BITS);
        if (ycc_mode == MODE_FULL)
        begin
            pending_ycc.push_back(rebuild_beat(y, round_fx(cb_fx, FRAC_BITS),
                                               round_fx(cr_fx, FRAC_BITS), 1'b1));
        end
        else if (!pair_half)
        begin
            // first of pair: held, nothing out yet
            held_y     = y;
            held_cb_fx = cb_fx;
            held_cr_fx = cr_fx;
            pair_half  = 1'b1;
        end
        else
        begin
            // shared chroma: one rounding of the summed unrounded values
            cb = round_fx(held_cb_fx + cb_fx, FRAC_BITS + 1);
            cr = round_fx(held_cr_fx + cr_fx, FRAC_BITS + 1);
            pending_ycc.push_back(rebuild_beat(held_y, cb, cr, 1'b0));
            pending_ycc.push_back(rebuild_beat(y, cb, cr, 1'b1));
            pair_half = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------
    // Pixel side: drive at the falling edge, accept at the rising edge
    // ---------------------------------------------------------------

    function automatic bit sender_idles();
        if (pixels_accepted >= QUIET_FROM && pixels_accepted < QUIET_TO)
            return 1'b0;
        return $urandom_range(99) < 15;
    endfunction

    // Returns once the beat has been taken; valid is left high so the
    // next pixel can follow back to back.
    task automatic send_pixel(input rgb_pixel_t p);
        @(negedge clk);
        while (sender_idles())
        begin
            pixel_valid = 1'b0;
            @(negedge clk);
        end
        pixel_valid = 1'b1;
        red   = p.red;
        green = p.green;
        blue  = p.blue;
        do
            @(posedge clk);
        while (pixel_stall);
        pixels_accepted++;
        if (pixels_accepted == HOLD_AT_PIXEL)
            hold_armed = 1'b1;
    endtask

    // Stop offering and wait until every owed beat has been seen
    task automatic drain_results();
        @(negedge clk);
        pixel_valid = 1'b0;
        while (pending_ycc.size() != 0)
            @(posedge clk);
    endtask

    // Mode writes happen only with the block idle. A held first-of-pair
    // pixel is dropped by the write.
    task automatic write_chroma_mode(input logic m);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = m;
        @(posedge clk);
        ycc_mode  = m;
        pair_half = 1'b0;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Mostly random pixels, plus saturated, gray and near-rail mixes so the
    // rebuild clamps get hit often.
    function automatic rgb_pixel_t random_pixel();
        rgb_pixel_t p;
        int pick;
        pick = $urandom_range(9);
        p.red   = PIX_W'($urandom);
        p.green = PIX_W'($urandom);
        p.blue  = PIX_W'($urandom);
        case (pick)
            6:
            begin
                p.red   = $urandom_range(1) ? 8'hFF : 8'h00;
                p.green = $urandom_range(1) ? 8'hFF : 8'h00;
                p.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
            end
            7:
            begin
                p.green = p.red;
                p.blue  = p.red;
            end
            8:
            begin
                p.red   = $urandom_range(1) ? PIX_W'($urandom_range(3))
                                            : PIX_W'($urandom_range(255, 252));
                p.blue  = $urandom_range(1) ? PIX_W'($urandom_range(3))
                                            : PIX_W'($urandom_range(255, 252));
            end
            default:
            begin
            end
        endcase
        return p;
    endfunction

    function automatic stim_row_t pixel_row(input int r, input int g, input int b);
        stim_row_t s;
        s.kind  = ROW_PIXEL;
        s.pix   = '{red: PIX_W'(r), green: PIX_W'(g), blue: PIX_W'(b)};
        s.mode  = MODE_FULL;
        s.typed = 1'b0;
        s.want  = '0;
        return s;
    endfunction

    function automatic stim_row_t mode_row(input logic m);
        stim_row_t s;
        s = pixel_row(0, 0, 0);
        s.kind = ROW_MODE;
        s.mode = m;
        return s;
    endfunction

    // Gray pixels in full chroma mode: luma is level minus 128, no chroma,
    // and the rebuild gives the level back exactly.
    function automatic stim_row_t gray_row(input int lvl, input int y_want);
        stim_row_t s;
        s = pixel_row(lvl, lvl, lvl);
        s.typed = 1'b1;
        s.want  = '{luma: PIX_W'(y_want), chroma_blue: '0, chroma_red: '0,
                    red_rebuilt: PIX_W'(lvl), green_rebuilt: PIX_W'(lvl),
                    blue_rebuilt: PIX_W'(lvl), last: 1'b1};
        return s;
    endfunction

    // ---------------------------------------------------------------
    // Result side: stall chosen at the falling edge, beat taken at the
    // rising edge and compared with the oldest owed beat.
    // ---------------------------------------------------------------
    initial
    begin
        ycc_beat_t want;
        forever
        begin
            @(negedge clk);
            if (hold_armed && !hold_done)
            begin
                // long hold-off while pixels keep coming: fills the block
                result_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            if (beats_checked >= QUIET_FROM && beats_checked < QUIET_TO)
                result_stall = 1'b0;
            else
                result_stall = $urandom_range(99) < 15;
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                beats_checked++;
                if (pending_ycc.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errors++;
                end
                else
                begin
                    want = pending_ycc.pop_front();
                    if (luma !== want.luma)
                    begin
                        $error("luma: expected %0d, got %0d", want.luma, luma);
                        errors++;
                    end
                    if (chroma_blue !== want.chroma_blue)
                    begin
                        $error("chroma_blue: expected %0d, got %0d",
                               want.chroma_blue, chroma_blue);
                        errors++;
                    end
                    if (chroma_red !== want.chroma_red)
                    begin
                        $error("chroma_red: expected %0d, got %0d",
                               want.chroma_red, chroma_red);
                        errors++;
                    end
                    if (red_rebuilt !== want.red_rebuilt)
                    begin
                        $error("red_rebuilt: expected %0d, got %0d",
                               want.red_rebuilt, red_rebuilt);
                        errors++;
                    end
                    if (green_rebuilt !== want.green_rebuilt)
                    begin
                        $error("green_rebuilt: expected %0d, got %0d",
                               want.green_rebuilt, green_rebuilt);
                        errors++;
                    end
                    if (blue_rebuilt !== want.blue_rebuilt)
                    begin
                        $error("blue_rebuilt: expected %0d, got %0d",
                               want.blue_rebuilt, blue_rebuilt);
                        errors++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        errors++;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial
    begin
        stim_row_t directed[$];
        rgb_pixel_t p;
        int n_items;
        logic m;

        // Directed table. Full chroma mode after reset first: grays with
        // hand-written results, then primaries, secondaries, an orange and bit patterns.
        directed.push_back(gray_row(0, -128));
        directed.push_back(gray_row(255, 127));
        directed.push_back(gray_row(128, 0));
        directed.push_back(gray_row(127, -1));
        directed.push_back(gray_row(1, -127));
        directed.push_back(pixel_row(255, 0, 0));
        directed.push_back(pixel_row(0, 255, 0));
        directed.push_back(pixel_row(0, 0, 255));
        directed.push_back(pixel_row(255, 255, 0));
        directed.push_back(pixel_row(0, 255, 255));
        directed.push_back(pixel_row(255, 0, 255));
        directed.push_back(pixel_row(255, 128, 0));
        directed.push_back(pixel_row(8'h55, 8'hAA, 8'h55));
        directed.push_back(pixel_row(8'hAA, 8'h55, 8'hAA));
        // Pair mode: rail-to-rail pairs, so shared chroma swings widest
        directed.push_back(mode_row(MODE_PAIR));
        directed.push_back(pixel_row(0, 0, 0));
        directed.push_back(pixel_row(255, 255, 255));
        directed.push_back(pixel_row(255, 0, 0));
        directed.push_back(pixel_row(0, 255, 255));
        directed.push_back(pixel_row(0, 0, 255));
        directed.push_back(pixel_row(255, 255, 0));
        // Mode write with a first-of-pair pixel held: that pixel is lost
        directed.push_back(pixel_row(10, 200, 30));
        directed.push_back(mode_row(MODE_PAIR));
        directed.push_back(pixel_row(255, 0, 255));
        directed.push_back(pixel_row(0, 255, 0));
        directed.push_back(mode_row(MODE_FULL));
        directed.push_back(pixel_row(77, 150, 29));

        // Reset once
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_MODE)
            begin
                write_chroma_mode(directed[i].mode);
            end
            else
            begin
                send_pixel(directed[i].pix);
                if (directed[i].typed)
                    pending_ycc.push_back(directed[i].want);
                else
                    predict_pixel(directed[i].pix);
            end
        end

        // Random phases: pair mode, full mode, then random modes. Odd pixel
        // counts leave a held pixel for the next mode write to drop.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph == 0)
                m = MODE_PAIR;
            else if (ph == 1)
                m = MODE_FULL;
            else
                m = logic'($urandom_range(1));
            write_chroma_mode(m);
            n_items = $urandom_range(136, 120);
            for (int k = 0; k < n_items; k++)
            begin
                // once: sender waits out every owed beat mid-phase
                if (ph == 2 && k == 40)
                    drain_results();
                p = random_pixel();
                send_pixel(p);
                predict_pixel(p);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
sv/rycc_pkg.sv
sv/rycc_mac.sv
sv/rgb_ycbcr_chroma_pair_roundtrip.sv
test/tb_rgb_ycbcr_chroma_pair_roundtrip.sv
